### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helper macros used by the checker file of the project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication violated");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");

`endif

### rtl/smd_pkg.sv
// ----------------------------------------------------------------------------
// smd_pkg
// Constants shared by the switch matrix debounce block and its checker.
// ----------------------------------------------------------------------------
package smd_pkg;

  localparam int ROW_COUNT            = 3;
  localparam int DEF_BITS_PER_ROW     = 12;

  localparam int TIME_W               = 63;
  localparam int DT_W                 = 32;
  localparam int MASK_W               = 36;

  localparam int CFG_IDX_W            = 8;
  localparam int CFG_DATA_W           = 36;

  localparam logic [DT_W-1:0]   DEBOUNCE_TIME_RESET = 32'd20000000;
  // Row 2, bits 8 to 11 bypassed by default.
  localparam logic [MASK_W-1:0] BYPASS_MASK_RESET   = 36'hF00000000;

  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_TIME = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BYPASS_MASK   = 8'd1;

endpackage

### rtl/smd_ram.sv
// ----------------------------------------------------------------------------
// smd_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module smd_ram #(
  parameter int WIDTH  = 63,
  parameter int DEPTH  = 36,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/switch_matrix_debounce.sv
// ----------------------------------------------------------------------------
// switch_matrix_debounce
// Per-switch, time-based debouncer for a scanned matrix of three switch rows.
//
// Each input beat is one scanned frame (three raw rows and a timestamp) and
// yields exactly one output beat carrying the debounced rows and a flag that
// is set when any debounced level flipped, or when the frame was the first
// one after reset. The last-change timestamps of all switches live in a small
// RAM, and a sequencer walks the switches one per cycle, reading a timestamp
// in one cycle and comparing the elapsed time against the debounce time in
// the next, so that one subtract-and-compare unit serves every switch. A
// normal frame therefore walks all ROW_COUNT*BITS_PER_ROW switches (twelve
// per row by default) through the single RAM read port; the first frame
// after reset instead fills the RAM with its timestamp, one entry a cycle.
// The input is stalled while a frame is in work, but a new frame may be
// taken while the previous result still waits on a stalled output.
// Configuration writes are expected only while the block is idle and take
// effect from the next frame; an unknown register index is ignored.
// Timestamps wrap modulo 2^63, so a timestamp that steps backwards looks
// like a very long hold.
// ----------------------------------------------------------------------------
module switch_matrix_debounce
  import smd_pkg::*;
#(
  parameter int BITS_PER_ROW = DEF_BITS_PER_ROW
) (
  input  logic                    clk,
  input  logic                    rst_n,

  input  logic                    cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,

  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [BITS_PER_ROW-1:0] in_raw_row0,
  input  logic [BITS_PER_ROW-1:0] in_raw_row1,
  input  logic [BITS_PER_ROW-1:0] in_raw_row2,
  input  logic [TIME_W-1:0]       in_sample_time,

  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [BITS_PER_ROW-1:0] out_stable_row0,
  output logic [BITS_PER_ROW-1:0] out_stable_row1,
  output logic [BITS_PER_ROW-1:0] out_stable_row2,
  output logic                    out_level_changed
);

  // Switches are numbered row by row: row r, bit b is switch BITS_PER_ROW*r+b.
  localparam int NBITS = ROW_COUNT * BITS_PER_ROW;
  localparam int IDX_W = (NBITS > 1) ? $clog2(NBITS) : 1;
  localparam int CNT_W = $clog2(NBITS + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PRIME,
    ST_SCAN,
    ST_DONE
  } state_t;

  state_t            state_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              primed_r;
  logic              changed_r;
  logic [NBITS-1:0]  raw_r;
  logic [NBITS-1:0]  cand_r;
  logic [NBITS-1:0]  stable_r;
  logic [TIME_W-1:0] now_r;
  logic [DT_W-1:0]   dt_r;
  logic [MASK_W-1:0] mask_r;

  // Evaluation stage: the switch whose timestamp is on the RAM read port.
  logic              ev_vld_r;
  logic [IDX_W-1:0]  ev_idx_r;

  logic              out_valid_r;
  logic [NBITS-1:0]  out_rows_r;
  logic              out_changed_r;

  logic              in_accept;
  logic              out_accept;
  logic              hand_over;
  logic [NBITS-1:0]  raw_flat;
  logic [NBITS-1:0]  byp_vec;
  logic [IDX_W-1:0]  cnt_idx;
  logic              scan_more;

  logic              ram_wr_en;
  logic [IDX_W-1:0]  ram_wr_addr;
  logic              ram_rd_en;
  logic [TIME_W-1:0] ram_rd_data;

  logic              ev_flip;
  logic              ev_differs;
  logic [TIME_W-1:0] ev_elapsed;
  logic              ev_take;

  assign in_stall   = (state_r != ST_IDLE);
  assign in_accept  = in_valid && !in_stall;
  assign out_accept = out_valid_r && !out_stall;
  // A finished frame moves to the output register once it is free or being
  // emptied in the same cycle.
  assign hand_over  = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  assign raw_flat  = {in_raw_row2, in_raw_row1, in_raw_row0};
  assign cnt_idx   = cnt_r[IDX_W-1:0];
  assign scan_more = (cnt_r < CNT_W'(NBITS));

  // Only the switches covered by the mask register can be bypassed.
  for (genvar g = 0; g < NBITS; g++) begin : g_byp
    if (g < MASK_W) begin : g_in
      assign byp_vec[g] = mask_r[g];
    end else begin : g_out
      assign byp_vec[g] = 1'b0;
    end
  end

  // Timestamp store. During priming every entry is written with the frame's
  // time; during a scan an entry is rewritten when its candidate flips.
  assign ram_wr_en   = (state_r == ST_PRIME) || ((state_r == ST_SCAN) && ev_vld_r && ev_flip);
  assign ram_wr_addr = (state_r == ST_PRIME) ? cnt_idx : ev_idx_r;
  assign ram_rd_en   = (state_r == ST_SCAN) && scan_more;

  smd_ram #(
    .WIDTH (TIME_W),
    .DEPTH (NBITS)
  ) u_time_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (now_r),
    .rd_en   (ram_rd_en),
    .rd_addr (cnt_idx),
    .rd_data (ram_rd_data)
  );

  // Shared evaluation unit. A freshly flipped candidate has held for no time
  // at all, so it only settles at once when bypassed or with a zero hold.
  // The new candidate level is always the raw level of the frame.
  always_comb begin
    ev_flip    = raw_r[ev_idx_r] ^ cand_r[ev_idx_r];
    ev_differs = stable_r[ev_idx_r] ^ raw_r[ev_idx_r];
    ev_elapsed = ev_flip ? '0 : (now_r - ram_rd_data);
    ev_take    = ev_differs &&
                 (byp_vec[ev_idx_r] || (ev_elapsed >= {{(TIME_W-DT_W){1'b0}}, dt_r}));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      cnt_r         <= '0;
      primed_r      <= 1'b0;
      changed_r     <= 1'b0;
      cand_r        <= '0;
      stable_r      <= '0;
      dt_r          <= DEBOUNCE_TIME_RESET;
      mask_r        <= BYPASS_MASK_RESET;
      ev_vld_r      <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_DEBOUNCE_TIME: dt_r   <= cfg_data[DT_W-1:0];
          CFG_BYPASS_MASK:   mask_r <= cfg_data[MASK_W-1:0];
          default: ;
        endcase
      end

      // A new result takes precedence over the beat leaving in this cycle.
      if (hand_over) begin
        out_valid_r <= 1'b1;
      end else if (out_accept) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_accept) begin
            raw_r    <= raw_flat;
            now_r    <= in_sample_time;
            cnt_r    <= '0;
            ev_vld_r <= 1'b0;
            if (primed_r) begin
              changed_r <= 1'b0;
              state_r   <= ST_SCAN;
            end else begin
              // The first frame loads both levels directly.
              cand_r    <= raw_flat;
              stable_r  <= raw_flat;
              changed_r <= 1'b1;
              primed_r  <= 1'b1;
              state_r   <= ST_PRIME;
            end
          end
        end

        ST_PRIME: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(NBITS - 1)) begin
            state_r <= ST_DONE;
          end
        end

        ST_SCAN: begin
          if (ev_vld_r) begin
            cand_r[ev_idx_r] <= raw_r[ev_idx_r];
            if (ev_take) begin
              stable_r[ev_idx_r] <= raw_r[ev_idx_r];
              changed_r          <= 1'b1;
            end
          end
          if (scan_more) begin
            ev_vld_r <= 1'b1;
            ev_idx_r <= cnt_idx;
            cnt_r    <= cnt_r + 1'b1;
          end else begin
            ev_vld_r <= 1'b0;
            state_r  <= ST_DONE;
          end
        end

        ST_DONE: begin
          // Hand over once the output register is free or being emptied.
          if (hand_over) begin
            out_rows_r    <= stable_r;
            out_changed_r <= changed_r;
            state_r       <= ST_IDLE;
          end
        end

        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_stable_row0   = out_rows_r[BITS_PER_ROW-1:0];
  assign out_stable_row1   = out_rows_r[2*BITS_PER_ROW-1:BITS_PER_ROW];
  assign out_stable_row2   = out_rows_r[3*BITS_PER_ROW-1:2*BITS_PER_ROW];
  assign out_level_changed = out_changed_r;

endmodule

### rtl/smd_checker.sv
// ----------------------------------------------------------------------------
// smd_checker
// Port-level assertions for the switch matrix debounce block, bound to it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module smd_checker
  import smd_pkg::*;
#(
  parameter int BITS_PER_ROW = DEF_BITS_PER_ROW
) (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    cfg_wr_en,
  input logic [CFG_IDX_W-1:0]    cfg_index,
  input logic [CFG_DATA_W-1:0]   cfg_data,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic [BITS_PER_ROW-1:0] in_raw_row0,
  input logic [BITS_PER_ROW-1:0] in_raw_row1,
  input logic [BITS_PER_ROW-1:0] in_raw_row2,
  input logic [TIME_W-1:0]       in_sample_time,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic [BITS_PER_ROW-1:0] out_stable_row0,
  input logic [BITS_PER_ROW-1:0] out_stable_row1,
  input logic [BITS_PER_ROW-1:0] out_stable_row2,
  input logic                    out_level_changed
);

  // The whole result beat, gathered for the hold check.
  logic [3*BITS_PER_ROW:0] out_beat;

  assign out_beat = {out_stable_row2, out_stable_row1, out_stable_row0, out_level_changed};

  // A frame in work keeps the input closed in the following cycle.
  `ASSERT_NEXT(a_busy_after_beat, clk, rst_n, in_valid && !in_stall, in_stall)

  // A new result only appears after the block has been busy with a frame.
  `ASSERT_SAME(a_result_after_work, clk, rst_n, $rose(out_valid), $past(in_stall))

  // A stalled result beat holds.
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_beat))

endmodule

bind switch_matrix_debounce smd_checker #(.BITS_PER_ROW(BITS_PER_ROW)) u_smd_checker (.*);
